### src/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  // Divider width and the side data that rides through it
  localparam int DIV_W = 64;
  localparam int TAG_W = 34;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEMP_TRIM = 3'd0;
  localparam logic [2:0] CFG_PRES_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRES_MID  = 3'd2;
  localparam logic [2:0] CFG_PRES_HIGH = 3'd3;
  localparam logic [2:0] CFG_HUM_TRIM  = 3'd4;

  // Result limits
  localparam logic signed [63:0] PMIN_Q8 = 64'sd7680000;
  localparam logic signed [63:0] PMAX_Q8 = 64'sd28160000;
  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;
  localparam logic [25:0] PRES_OUT_MIN = 26'd15360000;

endpackage

### src/env_sensor_compensation.sv
`timescale 1ns / 1ps
// Environmental sensor compensation pipeline.
// Input channel: one beat carries a raw temperature, pressure and humidity
// reading set (in_valid / in_stall). Result channel: one beat per input beat
// with temperature in 0.01 degC, humidity in 1/1024 %RH and pressure plus a
// 30000 Pa offset in 1/256 Pa, and a flag for a zero pressure divisor
// (out_valid / out_stall).
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data write the
// trim registers; cfg_ready is always high. Write only while no beat is in
// flight.
// Pipeline: the 64-bit signed divide of the pressure formula has an operand
// register, then one quotient bit per stage, then a sign stage; nine stages
// of temperature, humidity and pressure math precede it and three pressure
// stages follow.
// Throughput: one beat per cycle while the result beat is not stalled.
// Reset clears all valid bits and trims to zero; data in flight is dropped.
// While out_valid is high and out_stall is high the whole pipeline holds
// and in_stall goes high; nothing is lost or repeated.
module env_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  input  logic [15:0]        in_raw_humidity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temperature_centi,
  output logic [16:0]        out_humidity_q10,
  output logic [25:0]        out_pressure_q8,
  output logic               out_pressure_invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Trim registers
  logic [47:0] temp_trim_r;
  logic [63:0] pres_low_r;
  logic [63:0] pres_mid_r;
  logic [15:0] pres_high_r;
  logic [63:0] hum_trim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r <= '0;
      pres_low_r  <= '0;
      pres_mid_r  <= '0;
      pres_high_r <= '0;
      hum_trim_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        esc_pkg::CFG_TEMP_TRIM: temp_trim_r <= cfg_data[47:0];
        esc_pkg::CFG_PRES_LOW:  pres_low_r  <= cfg_data;
        esc_pkg::CFG_PRES_MID:  pres_mid_r  <= cfg_data;
        esc_pkg::CFG_PRES_HIGH: pres_high_r <= cfg_data[15:0];
        esc_pkg::CFG_HUM_TRIM:  hum_trim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode trims, sign-extended except t1, h1, h3 and p1, which are unsigned
  logic [15:0]        t1;
  logic signed [31:0] t2_s, t3_s;
  logic signed [31:0] h1_s, h2_s, h3_s, h5_s, h6_s;
  logic signed [63:0] p1_s, p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;

  assign t1   = temp_trim_r[15:0];
  assign t2_s = $signed({{16{temp_trim_r[31]}}, temp_trim_r[31:16]});
  assign t3_s = $signed({{16{temp_trim_r[47]}}, temp_trim_r[47:32]});
  assign h1_s = $signed({24'd0, hum_trim_r[7:0]});
  assign h2_s = $signed({{16{hum_trim_r[23]}}, hum_trim_r[23:8]});
  assign h3_s = $signed({24'd0, hum_trim_r[31:24]});
  assign h5_s = $signed({{20{hum_trim_r[55]}}, hum_trim_r[55:44]});
  assign h6_s = $signed({{24{hum_trim_r[63]}}, hum_trim_r[63:56]});
  assign p1_s = $signed({48'd0, pres_low_r[15:0]});
  assign p2_s = $signed({{48{pres_low_r[31]}}, pres_low_r[31:16]});
  assign p3_s = $signed({{48{pres_low_r[47]}}, pres_low_r[47:32]});
  assign p4_s = $signed({{48{pres_low_r[63]}}, pres_low_r[63:48]});
  assign p5_s = $signed({{48{pres_mid_r[15]}}, pres_mid_r[15:0]});
  assign p6_s = $signed({{48{pres_mid_r[31]}}, pres_mid_r[31:16]});
  assign p7_s = $signed({{48{pres_mid_r[47]}}, pres_mid_r[47:32]});
  assign p8_s = $signed({{48{pres_mid_r[63]}}, pres_mid_r[63:48]});
  assign p9_s = $signed({{48{pres_high_r[15]}}, pres_high_r[15:0]});

  // Pipeline enable: hold everything while the result beat is stalled
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic [8:0] pv_r;
  logic       div_vld;
  logic       d1_v_r, d2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      d1_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= {pv_r[7:0], in_valid};
      d1_v_r      <= div_vld;
      d2_v_r      <= d1_v_r;
      out_valid_r <= d2_v_r;
    end
  end

  // Stage 1: temperature products
  logic signed [31:0] a1, dt;
  logic signed [31:0] s1_v1p_r, s1_dd_r;
  logic [19:0]        s1_adcp_r;
  logic [15:0]        s1_adch_r;
  logic signed [31:0] s1_v1p_nxt, s1_dd_nxt;

  always_comb begin
    a1 = $signed({15'd0, in_raw_temperature[19:3]} - {15'd0, t1, 1'b0});
    dt = $signed({16'd0, in_raw_temperature[19:4]} - {16'd0, t1});
    s1_v1p_nxt = a1 * t2_s;
    s1_dd_nxt  = dt * dt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v1p_r  <= s1_v1p_nxt;
      s1_dd_r   <= s1_dd_nxt;
      s1_adcp_r <= in_raw_pressure;
      s1_adch_r <= in_raw_humidity;
    end
  end

  // Stage 2: second-order temperature term
  logic signed [31:0] dd_sh;
  logic signed [31:0] s2_v1_r, s2_v2p_r, s2_v1_nxt, s2_v2p_nxt;
  logic [19:0]        s2_adcp_r;
  logic [15:0]        s2_adch_r;

  always_comb begin
    dd_sh      = s1_dd_r >>> 12;
    s2_v1_nxt  = s1_v1p_r >>> 11;
    s2_v2p_nxt = dd_sh * t3_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v1_r   <= s2_v1_nxt;
      s2_v2p_r  <= s2_v2p_nxt;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
    end
  end

  // Stage 3: fine temperature
  logic signed [31:0] s3_tfine_r, s3_tfine_nxt;
  logic [19:0]        s3_adcp_r;
  logic [15:0]        s3_adch_r;

  assign s3_tfine_nxt = s2_v1_r + (s2_v2p_r >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tfine_r <= s3_tfine_nxt;
      s3_adcp_r  <= s2_adcp_r;
      s3_adch_r  <= s2_adch_r;
    end
  end

  // Stage 4: temperature result, first humidity products, pressure offset
  logic signed [31:0] tc5, tcw, hx;
  logic signed [15:0] s4_tc_r, s4_tc_nxt;
  logic signed [31:0] s4_h5x_r, s4_bp_r, s4_cp_r;
  logic signed [31:0] s4_h5x_nxt, s4_bp_nxt, s4_cp_nxt;
  logic signed [32:0] s4_w1_r, s4_w1_nxt;
  logic [19:0]        s4_adcp_r;
  logic [15:0]        s4_adch_r;

  always_comb begin
    tc5 = s3_tfine_r * 32'sd5 + 32'sd128;
    tcw = tc5 >>> 8;
    if (tcw < -32'sd32768) begin
      s4_tc_nxt = -16'sd32768;
    end else if (tcw > 32'sd32767) begin
      s4_tc_nxt = 16'sd32767;
    end else begin
      s4_tc_nxt = tcw[15:0];
    end
    hx         = s3_tfine_r - 32'sd76800;
    s4_h5x_nxt = h5_s * hx;
    s4_bp_nxt  = hx * h6_s;
    s4_cp_nxt  = hx * h3_s;
    s4_w1_nxt  = $signed({s3_tfine_r[31], s3_tfine_r}) - 33'sd128000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tc_r   <= s4_tc_nxt;
      s4_h5x_r  <= s4_h5x_nxt;
      s4_bp_r   <= s4_bp_nxt;
      s4_cp_r   <= s4_cp_nxt;
      s4_w1_r   <= s4_w1_nxt;
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
    end
  end

  // Stage 5: humidity offset term, b*c, pressure square and linear terms
  logic signed [31:0] ha_sum, hb, hc;
  logic signed [31:0] s5_a_r, s5_bc_r, s5_a_nxt, s5_bc_nxt;
  logic signed [63:0] s5_ww_r, s5_wp5_r, s5_wp2_r;
  logic signed [63:0] s5_ww_nxt, s5_wp5_nxt, s5_wp2_nxt;
  logic signed [15:0] s5_tc_r;
  logic [19:0]        s5_adcp_r;

  always_comb begin
    ha_sum = $signed({2'd0, s4_adch_r, 14'd0}) - $signed({hum_trim_r[43:32], 20'd0})
             - s4_h5x_r + 32'sd16384;
    s5_a_nxt   = ha_sum >>> 15;
    hb         = s4_bp_r >>> 10;
    hc         = (s4_cp_r >>> 11) + 32'sd32768;
    s5_bc_nxt  = hb * hc;
    s5_ww_nxt  = s4_w1_r * s4_w1_r;
    s5_wp5_nxt = s4_w1_r * p5_s;
    s5_wp2_nxt = s4_w1_r * p2_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_a_r    <= s5_a_nxt;
      s5_bc_r   <= s5_bc_nxt;
      s5_ww_r   <= s5_ww_nxt;
      s5_wp5_r  <= s5_wp5_nxt;
      s5_wp2_r  <= s5_wp2_nxt;
      s5_tc_r   <= s4_tc_r;
      s5_adcp_r <= s4_adcp_r;
    end
  end

  // Stage 6: humidity scale product, pressure square terms
  logic signed [31:0] e_in;
  logic signed [31:0] s6_ep_r, s6_ep_nxt, s6_a_r;
  logic signed [63:0] s6_ww6_r, s6_ww3_r, s6_ww6_nxt, s6_ww3_nxt;
  logic signed [63:0] s6_wp5_r, s6_wp2_r;
  logic signed [15:0] s6_tc_r;
  logic [19:0]        s6_adcp_r;

  always_comb begin
    e_in       = (s5_bc_r >>> 10) + 32'sd2097152;
    s6_ep_nxt  = e_in * h2_s;
    s6_ww6_nxt = s5_ww_r * p6_s;
    s6_ww3_nxt = s5_ww_r * p3_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ep_r   <= s6_ep_nxt;
      s6_a_r    <= s5_a_r;
      s6_ww6_r  <= s6_ww6_nxt;
      s6_ww3_r  <= s6_ww3_nxt;
      s6_wp5_r  <= s5_wp5_r;
      s6_wp2_r  <= s5_wp2_r;
      s6_tc_r   <= s5_tc_r;
      s6_adcp_r <= s5_adcp_r;
    end
  end

  // Stage 7: humidity a*e, pressure sums
  logic signed [31:0] he;
  logic signed [31:0] s7_xh_r, s7_xh_nxt;
  logic signed [63:0] s7_w2_r, s7_w1b_r, s7_w2_nxt, s7_w1b_nxt;
  logic signed [15:0] s7_tc_r;
  logic [19:0]        s7_adcp_r;

  always_comb begin
    he         = (s6_ep_r + 32'sd8192) >>> 14;
    s7_xh_nxt  = s6_a_r * he;
    s7_w2_nxt  = s6_ww6_r + (s6_wp5_r <<< 17) + (p4_s <<< 35);
    s7_w1b_nxt = (s6_ww3_r >>> 8) + (s6_wp2_r <<< 12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_xh_r   <= s7_xh_nxt;
      s7_w2_r   <= s7_w2_nxt;
      s7_w1b_r  <= s7_w1b_nxt;
      s7_tc_r   <= s6_tc_r;
      s7_adcp_r <= s6_adcp_r;
    end
  end

  // Stage 8: humidity square, pressure divisor product and dividend
  logic signed [31:0] hs;
  logic [20:0]        pn;
  logic signed [63:0] num_base;
  logic signed [31:0] s8_ss_r, s8_ss_nxt, s8_xh_r;
  logic signed [63:0] s8_m_r, s8_num_r, s8_m_nxt, s8_num_nxt;
  logic signed [15:0] s8_tc_r;

  always_comb begin
    hs         = s7_xh_r >>> 15;
    s8_ss_nxt  = hs * hs;
    s8_m_nxt   = (64'sh0000800000000000 + s7_w1b_r) * p1_s;
    pn         = 21'd1048576 - {1'b0, s7_adcp_r};
    num_base   = $signed({12'd0, pn, 31'd0}) - s7_w2_r;
    s8_num_nxt = num_base * 64'sd3125;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ss_r  <= s8_ss_nxt;
      s8_xh_r  <= s7_xh_r;
      s8_m_r   <= s8_m_nxt;
      s8_num_r <= s8_num_nxt;
      s8_tc_r  <= s7_tc_r;
    end
  end

  // Stage 9: humidity correction product, pressure divisor
  logic signed [31:0] ss_sh;
  logic signed [31:0] s9_ss7_r, s9_ss7_nxt, s9_xh_r;
  logic signed [63:0] s9_w1c_r, s9_num_r;
  logic signed [15:0] s9_tc_r;

  always_comb begin
    ss_sh      = s8_ss_r >>> 7;
    s9_ss7_nxt = ss_sh * h1_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_ss7_r <= s9_ss7_nxt;
      s9_xh_r  <= s8_xh_r;
      s9_w1c_r <= s8_m_r >>> 33;
      s9_num_r <= s8_num_r;
      s9_tc_r  <= s8_tc_r;
    end
  end

  // Temperature and humidity results and the zero-divisor flag ride through the divider
  logic signed [31:0]        hx2;
  logic [16:0]               hum_q10;
  logic                      bad;
  logic [esc_pkg::TAG_W-1:0] div_in_tag, div_out_tag;
  logic [63:0]               div_quo;

  always_comb begin
    hx2 = s9_xh_r - (s9_ss7_r >>> 4);
    if (hx2 < 32'sd0) begin
      hum_q10 = '0;
    end else if (hx2 > esc_pkg::HUM_MAX) begin
      hum_q10 = esc_pkg::HUM_MAX[28:12];
    end else begin
      hum_q10 = hx2[28:12];
    end
    bad        = (s9_w1c_r == 64'sd0);
    div_in_tag = {s9_tc_r, hum_q10, bad};
  end

  esc_div #(
    .W  (esc_pkg::DIV_W),
    .PW (esc_pkg::TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pv_r[8]),
    .num     (s9_num_r),
    .den     (s9_w1c_r),
    .in_tag  (div_in_tag),
    .out_vld (div_vld),
    .quo     (div_quo),
    .out_tag (div_out_tag)
  );

  // Post stage 1: quadratic and linear correction products
  logic signed [63:0] dq_p, dq_q;
  logic signed [63:0] d1_p_r, d1_q_r, d1_pq_r, d1_r2p_r, d1_pq_nxt, d1_r2p_nxt;
  logic [esc_pkg::TAG_W-1:0] d1_tag_r;

  always_comb begin
    dq_p       = $signed(div_quo);
    dq_q       = dq_p >>> 13;
    d1_pq_nxt  = p9_s * dq_q;
    d1_r2p_nxt = p8_s * dq_p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_p_r   <= dq_p;
      d1_q_r   <= dq_q;
      d1_pq_r  <= d1_pq_nxt;
      d1_r2p_r <= d1_r2p_nxt;
      d1_tag_r <= div_out_tag;
    end
  end

  // Post stage 2: split 64x64 low product into 32-bit partials
  logic [63:0]        d2_pl_r, d2_pl_nxt;
  logic [31:0]        d2_pm_r, d2_pm_nxt;
  logic [31:0]        pm_a, pm_b;
  logic signed [63:0] d2_p_r, d2_r2p_r;
  logic [esc_pkg::TAG_W-1:0] d2_tag_r;

  always_comb begin
    d2_pl_nxt = {32'd0, d1_pq_r[31:0]} * {32'd0, d1_q_r[31:0]};
    pm_a      = d1_pq_r[31:0] * d1_q_r[63:32];
    pm_b      = d1_pq_r[63:32] * d1_q_r[31:0];
    d2_pm_nxt = pm_a + pm_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_pl_r  <= d2_pl_nxt;
      d2_pm_r  <= d2_pm_nxt;
      d2_p_r   <= d1_p_r;
      d2_r2p_r <= d1_r2p_r;
      d2_tag_r <= d1_tag_r;
    end
  end

  // Output stage: sum corrections, clamp, add offset, force minimum on a zero divisor
  logic [63:0]        pqq;
  logic signed [63:0] r1, r2, psum, pp, ppc, pout;
  logic [25:0]        pres_nxt;
  logic signed [15:0] out_tc_r;
  logic [16:0]        out_hum_r;
  logic [25:0]        out_pres_r;
  logic               out_bad_r;

  always_comb begin
    pqq  = d2_pl_r + {d2_pm_r, 32'd0};
    r1   = $signed(pqq) >>> 25;
    r2   = d2_r2p_r >>> 19;
    psum = d2_p_r + r1 + r2;
    pp   = (psum >>> 8) + (p7_s <<< 4);
    if (pp < esc_pkg::PMIN_Q8) begin
      ppc = esc_pkg::PMIN_Q8;
    end else if (pp > esc_pkg::PMAX_Q8) begin
      ppc = esc_pkg::PMAX_Q8;
    end else begin
      ppc = pp;
    end
    pout = ppc + esc_pkg::PMIN_Q8;
    if (d2_tag_r[0]) begin
      pres_nxt = esc_pkg::PRES_OUT_MIN;
    end else begin
      pres_nxt = pout[25:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tc_r   <= $signed(d2_tag_r[33:18]);
      out_hum_r  <= d2_tag_r[17:1];
      out_pres_r <= pres_nxt;
      out_bad_r  <= d2_tag_r[0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_tc_r;
  assign out_humidity_q10      = out_hum_r;
  assign out_pressure_q8       = out_pres_r;
  assign out_pressure_invalid  = out_bad_r;

`ifndef SYNTHESIS
  a_bad_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_pres_r == esc_pkg::PRES_OUT_MIN)
    else $error("invalid pressure not at minimum");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_hum_r <= 17'd102400)
    else $error("humidity above full scale");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pres_r >= 26'd15360000) && (out_pres_r <= 26'd35840000))
    else $error("pressure out of range");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pv_r) && $stable(d2_v_r))
    else $error("pipeline moved during stall");
`endif

endmodule

### src/esc_div.sv
`timescale 1ns / 1ps
module esc_div #(
  parameter int W  = esc_pkg::DIV_W,
  parameter int PW = esc_pkg::TAG_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [PW-1:0] in_tag,
  output logic          out_vld,
  output logic [W-1:0]  quo,
  output logic [PW-1:0] out_tag
);

  logic [W-1:0]  rem_r [0:W];
  logic [W-1:0]  nq_r  [0:W];
  logic [W-1:0]  dv_r  [0:W];
  logic [PW-1:0] tag_r [0:W];
  logic [W:0]    neg_r;
  logic [W:0]    vld_r;
  logic [W-1:0]  quo_r;
  logic [PW-1:0] fin_tag_r;
  logic          fin_vld_r;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;

  // Take magnitudes of both operands
  assign ua = num[W-1] ? (~num + 1'b1) : num;
  assign ub = den[W-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= ua;
      dv_r[0]  <= ub;
      neg_r[0] <= num[W-1] ^ den[W-1];
      tag_r[0] <= in_tag;
    end
  end

  // One quotient bit per stage, restoring form
  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W:0] rs;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      rs   = {rem_r[k-1], nq_r[k-1][W-1]};
      diff = rs - {1'b0, dv_r[k-1]};
      ge   = (rs >= {1'b0, dv_r[k-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[W-1:0] : rs[W-1:0];
        nq_r[k]  <= {nq_r[k-1][W-2:0], ge};
        dv_r[k]  <= dv_r[k-1];
        neg_r[k] <= neg_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // Restore the sign of the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r     <= neg_r[W] ? (~nq_r[W] + 1'b1) : nq_r[W];
      fin_tag_r <= tag_r[W];
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[W-1:0], in_vld};
      fin_vld_r <= vld_r[W];
    end
  end

  assign out_vld = fin_vld_r;
  assign quo     = quo_r;
  assign out_tag = fin_tag_r;

endmodule
